[rtl/core/aes_pkg.sv]
//------------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and round functions of the AES block encrypt core.
//------------------------------------------------------------------------------
package aes_pkg;

	localparam int MaxRoundsDefault = 14;
	localparam int MinRounds        = 10;
	localparam int CntW             = 4;

	typedef enum logic [0:0] {
		CMD_LOAD    = 1'b0,
		CMD_ENCRYPT = 1'b1
	} cmd_t;

	// Key store write request
	typedef struct packed {
		logic        we;
		logic [4:0]  waddr;
		logic [63:0] wdata;
	} key_wr_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Forward S-box
	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[v];
	endfunction

	// One AES round on a 128-bit state, byte i in bits 8i+7:8i (no key add)
	function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r + 4*c] = sbox(s[8*(r + 4*((c + r) % 4)) +: 8]);
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			if (mix) begin
				o[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end else begin
				o[8*(4*c)   +: 8] = a0;
				o[8*(4*c+1) +: 8] = a1;
				o[8*(4*c+2) +: 8] = a2;
				o[8*(4*c+3) +: 8] = a3;
			end
		end
		round_fn = o;
	endfunction

endpackage

[rtl/core/aes_key_mem.sv]
//------------------------------------------------------------------------------
// aes_key_mem
// Round-key store: two synchronous 64-bit banks (low and high halves),
// one write port, one registered read port per bank.
//------------------------------------------------------------------------------
module aes_key_mem #(
	parameter int MAX_ROUNDS = aes_pkg::MaxRoundsDefault,
	localparam int Depth = MAX_ROUNDS + 1,
	localparam int AW = $clog2(Depth)
) (
	input  logic             clk,
	input  aes_pkg::key_wr_t wr,
	input  logic [AW-1:0]    raddr,
	output logic [127:0]     rdata
);
	logic [63:0] mem_lo [Depth];
	logic [63:0] mem_hi [Depth];

	// write: entry bit 0 picks the bank
	always_ff @(posedge clk) begin
		if (wr.we && !wr.waddr[0]) mem_lo[wr.waddr[AW:1]] <= wr.wdata;
		if (wr.we &&  wr.waddr[0]) mem_hi[wr.waddr[AW:1]] <= wr.wdata;
	end

	// read, registered
	always_ff @(posedge clk) begin
		rdata <= {mem_hi[raddr], mem_lo[raddr]};
	end
endmodule

[rtl/core/aes_block_encrypt.sv]
//------------------------------------------------------------------------------
// aes_block_encrypt
// AES encryption with pre-expanded round keys held in a synchronous store.
//------------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | command key_index key_half key_data block_*
// out     | out | out_valid / out_ready | cipher_low cipher_high
// cfg     | in  | cfg_we                | cfg_wdata (round_count)
//
// An encrypt: the accepting cycle reads key 0, then the first run cycle adds
// it, then one round per cycle through the shared round unit, each key
// requested in the cycle before its round.
// The ciphertext moves to an output register; a new item is taken as soon as
// the encrypt has finished. An encrypt whose result register is still full
// waits in its last round until that item is taken.
// Reset clears control state and round_count to 10; no clearing pass.
//------------------------------------------------------------------------------
module aes_block_encrypt #(
	parameter int MAX_ROUNDS = aes_pkg::MaxRoundsDefault,
	localparam int AW = $clog2(MAX_ROUNDS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [3:0]  key_index,
	input  logic        key_half,
	input  logic [63:0] key_data,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_low,
	output logic [63:0] cipher_high
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t          state_q;
	logic [3:0]      round_count_q;
	logic [3:0]      rounds_q;
	logic [3:0]      rnd_q;
	logic            first_q;
	logic [127:0]    state_data_q;
	logic [127:0]    result_q;
	logic [AW-1:0]   raddr;
	logic [127:0]    rkey;
	logic [127:0]    rnd_out;
	aes_pkg::key_wr_t wr;
	logic            acc;
	logic [3:0]      eff_rounds;
	logic            last;
	logic            done;

	// effective round count, clamped
	always_comb begin
		eff_rounds = round_count_q;
		if (round_count_q < 4'(aes_pkg::MinRounds)) eff_rounds = 4'(aes_pkg::MinRounds);
		if (round_count_q > 4'(MAX_ROUNDS)) eff_rounds = 4'(MAX_ROUNDS);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign last     = (state_q == ST_RUN) && !first_q && (rnd_q == rounds_q);
	assign done     = last && (!out_valid || out_ready);

	// key store write from load items
	always_comb begin
		wr.we    = acc && (command == aes_pkg::CMD_LOAD) && (key_index <= 4'(MAX_ROUNDS));
		wr.waddr = {key_index, key_half};
		wr.wdata = key_data;
	end

	// read the key of the round being prepared; the last round keeps its key
	always_comb begin
		if (state_q == ST_RUN && first_q)      raddr = AW'(1);
		else if (state_q == ST_RUN && !last)   raddr = AW'(rnd_q + 4'd1);
		else if (state_q == ST_RUN)            raddr = AW'(rnd_q);
		else                                   raddr = '0;
	end

	aes_key_mem #(.MAX_ROUNDS(MAX_ROUNDS)) u_mem (
		.clk(clk), .wr(wr), .raddr(raddr), .rdata(rkey)
	);

	assign rnd_out = aes_pkg::round_fn(state_data_q, rnd_q != rounds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) round_count_q <= 4'(aes_pkg::MinRounds);
		else if (cfg_we) round_count_q <= cfg_wdata;
	end

	// sequencer: first run cycle adds key 0, then one round per cycle; the last round holds while the result is not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			first_q   <= 1'b0;
			rnd_q     <= '0;
			rounds_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && command == aes_pkg::CMD_ENCRYPT) begin
						state_q  <= ST_RUN;
						first_q  <= 1'b1;
						rnd_q    <= 4'd0;
						rounds_q <= eff_rounds;
					end
				end
				ST_RUN: begin
					if (first_q) begin
						first_q <= 1'b0;
						rnd_q   <= 4'd1;
					end else if (last) begin
						if (done) state_q <= ST_IDLE;
					end else begin
						rnd_q <= rnd_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc && command == aes_pkg::CMD_ENCRYPT)
			state_data_q <= {block_high, block_low};
		else if (state_q == ST_RUN && first_q)
			state_data_q <= state_data_q ^ rkey;
		else if (state_q == ST_RUN && !last)
			state_data_q <= rnd_out ^ rkey;
	end

	// output register, loaded by the final round
	always_ff @(posedge clk) begin
		if (done) result_q <= rnd_out ^ rkey;
	end

	assign cipher_low  = result_q[63:0];
	assign cipher_high = result_q[127:64];

	// key 0 is read at the accepting edge; key r is requested at rnd_q==r-1

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_low))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !in_ready)
		else $error("item accepted during encrypt");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid && state_q == ST_IDLE)
		else $error("finished encrypt gave no result");
endmodule
